@@ hw/rtl/crrc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrc_pkg
// Shared widths, pipeline payload type and arctangent table for the
// circle versus rotated rectangle collision core.
// ----------------------------------------------------------------------------
package crrc_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int FRAC_BITS_DEF     = 16;
  localparam int ATAN_LEN          = 24;
  localparam longint GAIN_Q30      = 64'd652032874;

  localparam int CW = 32;  // signed coordinate
  localparam int LW = 31;  // unsigned length
  localparam int AW = 34;  // anchor coordinate
  localparam int DW = 35;  // offset from anchor
  localparam int ZW = 32;  // CORDIC angle accumulator
  localparam int OW = 34;  // clamp offset

  localparam logic [2:0] ANCHOR_LU = 3'd0;
  localparam logic [2:0] ANCHOR_LL = 3'd1;
  localparam logic [2:0] ANCHOR_RU = 3'd2;
  localparam logic [2:0] ANCHOR_RL = 3'd3;

  typedef struct packed {
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [AW-1:0] ax;
    logic signed [AW-1:0] ay;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic [LW-1:0]        w;
    logic [LW-1:0]        h;
    logic [LW-1:0]        rad;
  } item_t;

  function automatic logic signed [ZW-1:0] atan_val(input int idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      0:  v = 32'sd536870912;
      1:  v = 32'sd316933406;
      2:  v = 32'sd167458907;
      3:  v = 32'sd85004756;
      4:  v = 32'sd42667331;
      5:  v = 32'sd21354465;
      6:  v = 32'sd10679838;
      7:  v = 32'sd5340245;
      8:  v = 32'sd2670163;
      9:  v = 32'sd1335087;
      10: v = 32'sd667544;
      11: v = 32'sd333772;
      12: v = 32'sd166886;
      13: v = 32'sd83443;
      14: v = 32'sd41722;
      15: v = 32'sd20861;
      16: v = 32'sd10430;
      17: v = 32'sd5215;
      18: v = 32'sd2608;
      19: v = 32'sd1304;
      20: v = 32'sd652;
      21: v = 32'sd326;
      22: v = 32'sd163;
      23: v = 32'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/circle_rotated_rect_collision_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_rotated_rect_collision_core
// Streaming test of a circle against a rotated rectangle, one word per cycle.
//
//  channel   direction  word contents
//  s_axis    in         circle, radius, rectangle, angle, anchor mode
//  m_axis    out        hit flag
//
// The pipeline runs through the CORDIC entry, iteration and quadrant stages,
// followed by multiply, rotate, clamp, square and compare stages.
// A new word is accepted every cycle while the output is taken.
// The whole pipeline holds when the output word is stalled.
// Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module circle_rotated_rect_collision_core #(
  parameter int CORDIC_STAGES = crrc_pkg::CORDIC_STAGES_DEF,
  parameter int FRAC_BITS     = crrc_pkg::FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // circle_x, circle_y, radius, rect_x, rect_y, rect_width, rect_height,
  // rect_angle, anchor_mode
  input  logic [239:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit, zero padding
  output logic [7:0]   m_axis_tdata
);
  import crrc_pkg::*;

  localparam int XW  = FRAC_BITS + 3;
  localparam int PW  = DW + XW;
  localparam int SW  = PW + 1;
  localparam int N   = CORDIC_STAGES;
  localparam int LAT = N + 7;

  logic           en;
  logic [LAT-1:0] vld_q;

  logic signed [CW-1:0] cx, cy, px, py;
  logic [LW-1:0]        rad, w, h;
  logic [15:0]          ang;
  logic [2:0]           mode;
  logic signed [AW-1:0] ax_d, ay_d;
  item_t                item_d;
  item_t                pay_q [0:N+1];

  logic signed [XW-1:0] cos_w, sin_w;
  logic signed [PW-1:0] mxc_q, mys_q, myc_q, mxs_q;
  item_t                m_q;
  logic signed [SW-1:0] accx, accy, fx, fy;
  logic signed [CW-1:0] ux_d, uy_d, ux_q, uy_q;
  item_t                r_q;
  logic signed [OW-1:0] ox, oy;
  logic [OW-1:0]        mgx, mgy;
  logic [LW-1:0]        mx_q, my_q, rad_c_q;
  logic                 okx_q, oky_q, ok_s_q;
  logic [2*LW-1:0]      sqx_q, sqy_q, r2_q;
  logic                 hit_q;

  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];
  assign m_axis_tdata  = {7'b0, hit_q};

  assign cx   = $signed(s_axis_tdata[31:0]);
  assign cy   = $signed(s_axis_tdata[63:32]);
  assign rad  = s_axis_tdata[94:64];
  assign px   = $signed(s_axis_tdata[126:95]);
  assign py   = $signed(s_axis_tdata[158:127]);
  assign w    = s_axis_tdata[189:159];
  assign h    = s_axis_tdata[220:190];
  assign ang  = s_axis_tdata[236:221];
  assign mode = s_axis_tdata[239:237];

  always_comb begin
    unique case (mode)
      ANCHOR_LU: begin ax_d = AW'(px);                ay_d = AW'(py); end
      ANCHOR_LL: begin ax_d = AW'(px);                ay_d = AW'(py) + AW'(h); end
      ANCHOR_RU: begin ax_d = AW'(px) + AW'(w);       ay_d = AW'(py); end
      ANCHOR_RL: begin ax_d = AW'(px) + AW'(w);       ay_d = AW'(py) + AW'(h); end
      default:   begin ax_d = AW'(px) + AW'(w >> 1);  ay_d = AW'(py) + AW'(h >> 1); end
    endcase
    item_d.dx  = DW'(cx) - DW'(ax_d);
    item_d.dy  = DW'(cy) - DW'(ay_d);
    item_d.ax  = ax_d;
    item_d.ay  = ay_d;
    item_d.px  = px;
    item_d.py  = py;
    item_d.w   = w;
    item_d.h   = h;
    item_d.rad = rad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  crrc_sincos #(
    .CORDIC_STAGES (CORDIC_STAGES),
    .FRAC_BITS     (FRAC_BITS)
  ) u_sincos (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (ang),
    .cos_o   (cos_w),
    .sin_o   (sin_w)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      pay_q[0] <= item_d;
    end
  end

  for (genvar k = 0; k <= N; k++) begin : g_delay
    always_ff @(posedge clk_i) begin
      if (en) begin
        pay_q[k+1] <= pay_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mxc_q <= PW'(pay_q[N+1].dx) * PW'(cos_w);
      mys_q <= PW'(pay_q[N+1].dy) * PW'(sin_w);
      myc_q <= PW'(pay_q[N+1].dy) * PW'(cos_w);
      mxs_q <= PW'(pay_q[N+1].dx) * PW'(sin_w);
      m_q   <= pay_q[N+1];
    end
  end

  always_comb begin
    accx = SW'(mxc_q) - SW'(mys_q) + (SW'(1) <<< (FRAC_BITS - 1));
    accy = SW'(myc_q) + SW'(mxs_q) + (SW'(1) <<< (FRAC_BITS - 1));
    fx   = (accx >>> FRAC_BITS) + SW'(m_q.ax);
    fy   = (accy >>> FRAC_BITS) + SW'(m_q.ay);
    if (fx > $signed(SW'(32'h7fff_ffff))) begin
      ux_d = 32'sh7fff_ffff;
    end else if (fx < SW'($signed(32'h8000_0000))) begin
      ux_d = $signed(32'h8000_0000);
    end else begin
      ux_d = fx[CW-1:0];
    end
    if (fy > $signed(SW'(32'h7fff_ffff))) begin
      uy_d = 32'sh7fff_ffff;
    end else if (fy < SW'($signed(32'h8000_0000))) begin
      uy_d = $signed(32'h8000_0000);
    end else begin
      uy_d = fy[CW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ux_q <= ux_d;
      uy_q <= uy_d;
      r_q  <= m_q;
    end
  end

  always_comb begin
    if (ux_q < r_q.px) begin
      ox = OW'(ux_q) - OW'(r_q.px);
    end else if (OW'(ux_q) > OW'(r_q.px) + $signed(OW'(r_q.w))) begin
      ox = OW'(ux_q) - OW'(r_q.px) - OW'(r_q.w);
    end else begin
      ox = '0;
    end
    if (uy_q < r_q.py) begin
      oy = OW'(uy_q) - OW'(r_q.py);
    end else if (OW'(uy_q) > OW'(r_q.py) + $signed(OW'(r_q.h))) begin
      oy = OW'(uy_q) - OW'(r_q.py) - OW'(r_q.h);
    end else begin
      oy = '0;
    end
    mgx = ox[OW-1] ? OW'(-ox) : OW'(ox);
    mgy = oy[OW-1] ? OW'(-oy) : OW'(oy);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q    <= mgx[LW-1:0];
      my_q    <= mgy[LW-1:0];
      okx_q   <= (mgx[OW-1:LW] == '0);
      oky_q   <= (mgy[OW-1:LW] == '0);
      rad_c_q <= r_q.rad;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q  <= mx_q * mx_q;
      sqy_q  <= my_q * my_q;
      r2_q   <= rad_c_q * rad_c_q;
      ok_s_q <= okx_q && oky_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= ok_s_q && (({1'b0, sqx_q} + {1'b0, sqy_q}) < {1'b0, r2_q});
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_zero_rad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_q[LAT-2] && (r2_q == '0) |=> !hit_q)
    else $error("hit reported for a zero radius");

  a_far: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_q[LAT-2] && !ok_s_q |=> !hit_q)
    else $error("hit reported for a far offset");

endmodule

@@ hw/rtl/crrc_sincos.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrc_sincos
// Pipelined CORDIC giving cosine and sine of minus the input binary angle,
// one register stage per iteration plus entry and quadrant stages.
// ----------------------------------------------------------------------------
module crrc_sincos #(
  parameter int CORDIC_STAGES = crrc_pkg::CORDIC_STAGES_DEF,
  parameter int FRAC_BITS     = crrc_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [15:0]                angle_i,
  output logic signed [FRAC_BITS+2:0] cos_o,
  output logic signed [FRAC_BITS+2:0] sin_o
);
  import crrc_pkg::*;

  localparam int XW = FRAC_BITS + 3;
  localparam int N  = CORDIC_STAGES;
  localparam longint K0 = (GAIN_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);

  logic signed [XW-1:0] x_q [0:N];
  logic signed [XW-1:0] y_q [0:N];
  logic signed [ZW-1:0] z_q [0:N];
  logic [1:0]           q_q [0:N];
  logic signed [XW-1:0] cos_q, sin_q;

  logic [15:0]        t;
  logic [16:0]        tt;
  logic [1:0]         q_d;
  logic signed [15:0] r_d;

  always_comb begin
    t   = 16'(17'h10000 - {1'b0, angle_i});
    tt  = {1'b0, t} + 17'h02000;
    q_d = tt[15:14];
    r_d = $signed(t - {q_d, 14'b0});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= XW'(K0);
      y_q[0] <= '0;
      z_q[0] <= {r_d, 16'b0};
      q_q[0] <= q_d;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[i+1] <= q_q[i];
        if (!z_q[i][ZW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_val(i);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_val(i);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      unique case (q_q[N])
        2'd0: begin cos_q <= x_q[N];  sin_q <= y_q[N];  end
        2'd1: begin cos_q <= -y_q[N]; sin_q <= x_q[N];  end
        2'd2: begin cos_q <= -x_q[N]; sin_q <= -y_q[N]; end
        default: begin cos_q <= y_q[N]; sin_q <= -x_q[N]; end
      endcase
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule
